// ===== rtl/hpg_pkg.sv =====
// Package with the types, constants and hue ramp function of the hue palette pixel generator.
package hpg_pkg;

    localparam int unsigned RecipShift = 16;
    localparam int unsigned RecipWidth = 17;
    localparam int unsigned HueWrap    = 1536;

    typedef logic [2:0][7:0] t_rgb;
    typedef logic [RecipWidth-1:0] t_recip;

    // Entry s holds ceil(2^16 / s); with a 16-bit shift this gives an exact
    // quotient for every dividend below 2^11 and every divisor up to 15.
    localparam t_recip RecipTable [16] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
        17'd10923, 17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,
        17'd5462,  17'd5042,  17'd4682,  17'd4370
    };

    // Fully saturated color on the six-segment ramp; index 0 is red.
    function automatic t_rgb hue_rgb(input logic [10:0] pos);
        logic [10:0] p;
        logic [7:0]  t;
        t_rgb        c;
        p = (pos >= 11'(HueWrap)) ? (pos - 11'(HueWrap)) : pos;
        t = p[7:0];
        case (p[10:8])
            3'd0:    c = '{8'd0,       t,         8'd255};
            3'd1:    c = '{8'd0,       8'd255,    8'd255 - t};
            3'd2:    c = '{t,          8'd255,    8'd0};
            3'd3:    c = '{8'd255,     8'd255 - t, 8'd0};
            3'd4:    c = '{8'd255,     8'd0,      t};
            default: c = '{8'd255 - t, 8'd0,      8'd255};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hue_palette_pixel_generator_top.sv =====
// Top level of the hue palette pixel generator: a seven-stage pixel pipeline.
//
// This block computes one pixel of a color-picker square per request: the hue
// position picks a saturated color, the row darkens it toward black and the
// column blends it from a grey that depends on the row. It takes one request
// per clock while o_ready is high and passes each result through all seven
// registered stages in order; every stage holds its own valid bit, so a stall on the
// output only stops the stages that are full, and empty stages keep filling.
// Divisions by the scale and by the square side use an exact reciprocal
// multiply, with the reciprocal looked up when the scale register is written.
// The scale register is written directly through i_cfg_we and i_cfg_wdata;
// zero reads as one and values above MAX_SCALE saturate to MAX_SCALE.
module hue_palette_pixel_generator_top #(
    parameter int MAX_SCALE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [10:0] i_hue_position,
    input  logic [10:0] i_column,
    input  logic [10:0] i_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    import hpg_pkg::*;

    // Reciprocal of the effective scale and the last valid coordinate.
    t_recip      r_recip;
    logic [11:0] r_side_m1;
    logic [3:0]  n_scale;

    always_comb begin
        if (i_cfg_wdata == 4'd0) begin
            n_scale = 4'd1;
        end else if (int'(i_cfg_wdata) > MAX_SCALE) begin
            n_scale = 4'(MAX_SCALE);
        end else begin
            n_scale = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip   <= RecipTable[1];
            r_side_m1 <= 12'd255;
        end else if (i_cfg_we) begin
            r_recip   <= RecipTable[n_scale];
            r_side_m1 <= {n_scale, 8'd0} - 12'd1;
        end
    end

    // Per-stage valid bits and load enables. A stage loads when it is empty
    // or when the stage after it is loading too.
    logic [7:1] r_v;
    logic [7:1] w_en;

    always_comb begin
        w_en[7] = !r_v[7] || i_ready;
        for (int k = 6; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[1];
    assign o_valid = r_v[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 7; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 1: clamp the coordinates and look up the hue color.
    logic [10:0] n_x, n_y;
    t_rgb        r1_c;
    logic [10:0] r1_x, r1_y;

    assign n_x = ({1'b0, i_column} > r_side_m1) ? r_side_m1[10:0] : i_column;
    assign n_y = ({1'b0, i_row} > r_side_m1) ? r_side_m1[10:0] : i_row;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_c <= hue_rgb(i_hue_position);
            r1_x <= n_x;
            r1_y <= n_y;
        end
    end

    // Stage 2: color times row, and row times the reciprocal for the grey.
    logic [2:0][18:0] r2_cy;
    logic [27:0]      r2_ym;
    t_rgb             r2_c;
    logic [10:0]      r2_x;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r2_cy[k] <= 19'(r1_c[k] * r1_y);
            end
            r2_ym <= 28'(r1_y * r_recip);
            r2_c  <= r1_c;
            r2_x  <= r1_x;
        end
    end

    // Stage 3: divide the darkening term by the scale; finish the grey.
    logic [2:0][27:0] r3_dm;
    logic [7:0]       r3_grey;
    t_rgb             r3_c;
    logic [10:0]      r3_x;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int k = 0; k < 3; k++) begin
                r3_dm[k] <= 28'(r2_cy[k][18:8] * r_recip);
            end
            r3_grey <= 8'd255 - r2_ym[23:16];
            r3_c    <= r2_c;
            r3_x    <= r2_x;
        end
    end

    // Stage 4: darkened color and its signed distance from the grey.
    logic [2:0][7:0] n4_d;
    logic [2:0][8:0] n4_diff;
    logic [2:0][7:0] r4_mag;
    logic [2:0]      r4_neg;
    logic [7:0]      r4_grey;
    logic [10:0]     r4_x;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_d[k]    = r3_c[k] - r3_dm[k][23:16];
            n4_diff[k] = {1'b0, n4_d[k]} - {1'b0, r3_grey};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r4_neg[k] <= n4_diff[k][8];
                r4_mag[k] <= n4_diff[k][8] ? 8'(-n4_diff[k]) : n4_diff[k][7:0];
            end
            r4_grey <= r3_grey;
            r4_x    <= r3_x;
        end
    end

    // Stage 5: column times the distance magnitude.
    logic [2:0][18:0] r5_p;
    logic [2:0]       r5_neg;
    logic [7:0]       r5_grey;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int k = 0; k < 3; k++) begin
                r5_p[k] <= 19'(r4_x * r4_mag[k]);
            end
            r5_neg  <= r4_neg;
            r5_grey <= r4_grey;
        end
    end

    // Stage 6: divide the blend term by the scale.
    logic [2:0][27:0] r6_qm;
    logic [2:0]       r6_neg;
    logic [7:0]       r6_grey;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r6_qm[k] <= 28'(r5_p[k][18:8] * r_recip);
            end
            r6_neg  <= r5_neg;
            r6_grey <= r5_grey;
        end
    end

    // Stage 7: apply the blend with its sign. The magnitude of the step never
    // exceeds the distance, so the result stays between grey and color.
    t_rgb r7_rgb;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int k = 0; k < 3; k++) begin
                r7_rgb[k] <= r6_neg[k] ? (r6_grey - r6_qm[k][23:16])
                                       : (r6_grey + r6_qm[k][23:16]);
            end
        end
    end

    assign o_red   = r7_rgb[0];
    assign o_green = r7_rgb[1];
    assign o_blue  = r7_rgb[2];

endmodule
